### rtl/core/kluc_pkg.sv
// Shared types and constants for the keyed LRU cache with owner purge.
// Used by kluc_front, kluc_back and the top level; depends on nothing.
package kluc_pkg;

    localparam int unsigned ENTRIES_DEF  = 32;
    localparam int unsigned IN_DATA_W    = 104;
    localparam int unsigned OUT_DATA_W   = 72;
    localparam int unsigned OUT_USER_W   = 3;

    typedef enum logic {
        OP_LOOKUP,
        OP_PURGE
    } t_op;

    typedef enum logic [2:0] {
        K_HIT      = 3'd0,
        K_INSERTED = 3'd1,
        K_FAILED   = 3'd2,
        K_REMOVED  = 3'd3,
        K_NONE     = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_MISS,
        S_SHIFT,
        S_INS,
        S_PURGE
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [31:0] key;
        logic [31:0] owner_id;
        logic [31:0] new_id;
        logic        create_ok;
    } t_item;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] owner;
        logic [31:0] variant;
        logic [63:0] stamp;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] result_id;
        logic        notify;
        logic        evicted_valid;
        logic [31:0] evicted_id;
        logic        last;
    } t_result;

endpackage

### rtl/core/kluc_front.sv
// Front end: accepts input beats, classifies them and holds them in a two-slot queue.
// Depends on kluc_pkg.
module kluc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_tvalid,
    output logic                                 o_tready,
    input  logic [kluc_pkg::IN_DATA_W-1:0]       i_tdata,
    input  logic                                 i_tuser,
    output logic                                 o_q_valid,
    output kluc_pkg::t_item                      o_q_item,
    input  logic                                 i_q_pop
);

    kluc_pkg::t_item r_slot [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    kluc_pkg::t_item w_item;
    logic            w_push;

    always_comb begin
        w_item.op        = i_tuser ? kluc_pkg::OP_PURGE : kluc_pkg::OP_LOOKUP;
        w_item.key       = i_tdata[31:0];
        w_item.owner_id  = i_tdata[63:32];
        w_item.new_id    = i_tdata[95:64];
        w_item.create_ok = i_tdata[96];
    end

    assign o_tready  = (r_cnt != 2'd2);
    assign w_push    = i_tvalid && o_tready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end

endmodule

### rtl/core/kluc_back.sv
// Back end: entry memory, scan sequencer for lookup, eviction and purge, and output register.
// Depends on kluc_pkg.
module kluc_back #(
    parameter int unsigned ENTRIES = kluc_pkg::ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  kluc_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output kluc_pkg::t_result    o_result
);

    localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    kluc_pkg::t_entry mem [ENTRIES];

    kluc_pkg::t_state  r_state, n_state;
    kluc_pkg::t_item   r_item, n_item;
    logic [CW-1:0]     r_used, n_used;
    logic [63:0]       r_access, n_access;
    logic [CW-1:0]     r_ra, n_ra;
    logic              r_pv, n_pv;
    logic [IW-1:0]     r_pi, n_pi;
    kluc_pkg::t_entry  r_rd;
    logic [63:0]       r_min, n_min;
    logic [IW-1:0]     r_old, n_old;
    logic [31:0]       r_oldvar, n_oldvar;
    logic [31:0]       r_ev, n_ev;
    logic [CW-1:0]     r_w, n_w;
    logic              r_pend, n_pend;
    logic [31:0]       r_pend_var, n_pend_var;
    logic              r_ovalid;
    kluc_pkg::t_result r_out;

    logic              w_re, w_we, w_emit, w_free, w_adv;
    logic [IW-1:0]     w_ra, w_wa;
    kluc_pkg::t_entry  w_wd;
    kluc_pkg::t_result w_res;

    assign w_free   = !r_ovalid || i_ready;
    assign o_valid  = r_ovalid;
    assign o_result = r_out;

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_used     = r_used;
        n_access   = r_access;
        n_ra       = r_ra;
        n_pv       = r_pv;
        n_pi       = r_pi;
        n_min      = r_min;
        n_old      = r_old;
        n_oldvar   = r_oldvar;
        n_ev       = r_ev;
        n_w        = r_w;
        n_pend     = r_pend;
        n_pend_var = r_pend_var;
        w_re       = 1'b0;
        w_ra       = r_ra[IW-1:0];
        w_we       = 1'b0;
        w_wa       = r_pi;
        w_wd       = r_rd;
        w_emit     = 1'b0;
        w_res      = '0;
        w_adv      = 1'b0;
        o_q_pop    = 1'b0;

        unique case (r_state)
            kluc_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_ra    = '0;
                    n_pv    = 1'b0;
                    n_w     = '0;
                    n_pend  = 1'b0;
                    n_state = (i_q_item.op == kluc_pkg::OP_PURGE) ? kluc_pkg::S_PURGE
                                                                  : kluc_pkg::S_LOOK;
                end
            end
            kluc_pkg::S_LOOK: begin
                if (r_pv) begin
                    if (r_rd.key == r_item.key) begin
                        if (w_free) begin
                            w_we            = 1'b1;
                            w_wa            = r_pi;
                            w_wd.stamp      = r_access + 64'd1;
                            n_access        = r_access + 64'd1;
                            w_emit          = 1'b1;
                            w_res.kind      = kluc_pkg::K_HIT;
                            w_res.result_id = r_rd.variant;
                            w_res.last      = 1'b1;
                            n_state         = kluc_pkg::S_IDLE;
                        end
                    end else begin
                        if (r_pi == '0 || r_rd.stamp < r_min) begin
                            n_min    = r_rd.stamp;
                            n_old    = r_pi;
                            n_oldvar = r_rd.variant;
                        end
                        w_adv = 1'b1;
                    end
                end else begin
                    w_adv = 1'b1;
                end
                if (w_adv) begin
                    if (r_ra < r_used) begin
                        w_re = 1'b1;
                        n_ra = r_ra + CW'(1);
                        n_pi = r_ra[IW-1:0];
                        n_pv = 1'b1;
                    end else begin
                        n_pv = 1'b0;
                        if (!r_pv) begin
                            n_state = kluc_pkg::S_MISS;
                        end
                    end
                end
            end
            kluc_pkg::S_MISS: begin
                if (!r_item.create_ok) begin
                    if (w_free) begin
                        w_emit          = 1'b1;
                        w_res.kind      = kluc_pkg::K_FAILED;
                        w_res.result_id = r_item.owner_id;
                        w_res.last      = 1'b1;
                        n_state         = kluc_pkg::S_IDLE;
                    end
                end else if (r_used == FULL) begin
                    n_ev    = r_oldvar;
                    n_ra    = CW'(r_old) + CW'(1);
                    n_pv    = 1'b0;
                    n_state = kluc_pkg::S_SHIFT;
                end else begin
                    n_ev    = '0;
                    n_state = kluc_pkg::S_INS;
                end
            end
            kluc_pkg::S_SHIFT: begin
                if (r_pv) begin
                    w_we = 1'b1;
                    w_wa = r_pi - IW'(1);
                end
                if (r_ra < r_used) begin
                    w_re = 1'b1;
                    n_ra = r_ra + CW'(1);
                    n_pi = r_ra[IW-1:0];
                    n_pv = 1'b1;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_used  = r_used - CW'(1);
                        n_state = kluc_pkg::S_INS;
                    end
                end
            end
            kluc_pkg::S_INS: begin
                if (w_free) begin
                    w_we                = 1'b1;
                    w_wa                = r_used[IW-1:0];
                    w_wd.key            = r_item.key;
                    w_wd.owner          = r_item.owner_id;
                    w_wd.variant        = r_item.new_id;
                    w_wd.stamp          = r_access + 64'd1;
                    n_access            = r_access + 64'd1;
                    n_used              = r_used + CW'(1);
                    w_emit              = 1'b1;
                    w_res.kind          = kluc_pkg::K_INSERTED;
                    w_res.result_id     = r_item.new_id;
                    w_res.evicted_valid = (r_ev != '0);
                    w_res.evicted_id    = r_ev;
                    w_res.last          = 1'b1;
                    n_state             = kluc_pkg::S_IDLE;
                end
            end
            kluc_pkg::S_PURGE: begin
                if (r_pv) begin
                    if (r_rd.owner == r_item.owner_id) begin
                        if (!r_pend) begin
                            n_pend     = 1'b1;
                            n_pend_var = r_rd.variant;
                            w_adv      = 1'b1;
                        end else if (w_free) begin
                            w_emit          = 1'b1;
                            w_res.kind      = kluc_pkg::K_REMOVED;
                            w_res.result_id = r_pend_var;
                            w_res.notify    = (r_pend_var != '0);
                            n_pend_var      = r_rd.variant;
                            w_adv           = 1'b1;
                        end
                    end else begin
                        w_we  = 1'b1;
                        w_wa  = r_w[IW-1:0];
                        n_w   = r_w + CW'(1);
                        w_adv = 1'b1;
                    end
                end else begin
                    w_adv = 1'b1;
                end
                if (w_adv) begin
                    if (r_ra < r_used) begin
                        w_re = 1'b1;
                        n_ra = r_ra + CW'(1);
                        n_pi = r_ra[IW-1:0];
                        n_pv = 1'b1;
                    end else begin
                        n_pv = 1'b0;
                        if (!r_pv && w_free) begin
                            w_emit     = 1'b1;
                            w_res.last = 1'b1;
                            if (r_pend) begin
                                w_res.kind      = kluc_pkg::K_REMOVED;
                                w_res.result_id = r_pend_var;
                                w_res.notify    = (r_pend_var != '0);
                            end else begin
                                w_res.kind = kluc_pkg::K_NONE;
                            end
                            n_pend  = 1'b0;
                            n_used  = r_w;
                            n_state = kluc_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = kluc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd <= mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kluc_pkg::S_IDLE;
            r_used   <= '0;
            r_access <= '0;
            r_pv     <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_access <= n_access;
            r_pv     <= n_pv;
            r_pend   <= n_pend;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_ra       <= n_ra;
        r_pi       <= n_pi;
        r_min      <= n_min;
        r_old      <= n_old;
        r_oldvar   <= n_oldvar;
        r_ev       <= n_ev;
        r_w        <= n_w;
        r_pend_var <= n_pend_var;
        if (w_emit) begin
            r_out <= w_res;
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FULL)
        else $error("Fill count exceeds the number of entries.");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (CW'(w_wa) <= r_used))
        else $error("Entry write beyond the packed region.");

    a_compact_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kluc_pkg::S_PURGE) |-> (r_w <= r_ra))
        else $error("Purge write pointer passed the read pointer.");

    a_stamp_with_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_access != $past(r_access)) |-> $past(w_we))
        else $error("Access counter moved without an entry write.");

endmodule

### rtl/core/keyed_lru_cache_with_owner_purge_unit.sv
// Top level of the keyed LRU cache with owner purge.
// A lookup scans the stored entries and answers with a hit, a failed miss or an insert.
// An insert may evict the least recently used entry; a purge marks its final beat as last.
// One item is worked on at a time, one entry per cycle while the output register can take a beat.
// Synchronous active-low reset empties the cache and clears the access counter.
// Depends on kluc_pkg, kluc_front and kluc_back.
module keyed_lru_cache_with_owner_purge_unit #(
    parameter int unsigned ENTRIES = kluc_pkg::ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // key, owner_id, new_id, create_ok, zero fill
    input  logic [kluc_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // func
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // result_id, notify, evicted_valid, evicted_id, zero fill
    output logic [kluc_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // kind
    output logic [kluc_pkg::OUT_USER_W-1:0]   o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);

    logic              w_q_valid;
    logic              w_q_pop;
    kluc_pkg::t_item   w_q_item;
    kluc_pkg::t_result w_res;

    kluc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (i_s_axis_tvalid),
        .o_tready  (o_s_axis_tready),
        .i_tdata   (i_s_axis_tdata),
        .i_tuser   (i_s_axis_tuser),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    kluc_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (w_res)
    );

    assign o_m_axis_tdata = {6'd0, w_res.evicted_id, w_res.evicted_valid,
                             w_res.notify, w_res.result_id};
    assign o_m_axis_tuser = w_res.kind;
    assign o_m_axis_tlast = w_res.last;

endmodule

### tb/tb_keyed_lru_cache_with_owner_purge_unit.sv
// Self-checking testbench for the keyed LRU cache with owner purge.
// Holds its own cache predictor and compares every output beat in order.
// Depends on kluc_pkg and keyed_lru_cache_with_owner_purge_unit.
`timescale 1ns / 1ps
module tb_keyed_lru_cache_with_owner_purge_unit;

    localparam int NSLOT = kluc_pkg::ENTRIES_DEF;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        kluc_pkg::t_kind kind;
        logic [31:0]     rid;
        logic            notify;
        logic            ev_valid;
        logic [31:0]     ev_id;
        logic            last;
    } t_expect;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [kluc_pkg::IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                            i_s_axis_tuser;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    logic [kluc_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [kluc_pkg::OUT_USER_W-1:0] o_m_axis_tuser;
    logic                            o_m_axis_tlast;

    keyed_lru_cache_with_owner_purge_unit dut (.*);

    // Predictor state: valid slots packed at the low indices in insertion order.
    int unsigned  slot_count;
    logic [31:0]  slot_key[NSLOT];
    logic [31:0]  slot_owner[NSLOT];
    logic [31:0]  slot_variant[NSLOT];
    logic [63:0]  slot_stamp[NSLOT];
    logic [63:0]  stamp_counter;

    t_expect      pending_results[$];
    int           mismatches;
    int           idle_cycles;
    int           send_gap_pct;
    int           recv_stall_pct;
    logic [31:0]  key_pool[8];
    logic [31:0]  owner_pool[4];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_expect make_result(kluc_pkg::t_kind kind, logic [31:0] rid,
                                            logic notify, logic ev_valid,
                                            logic [31:0] ev_id, logic last);
        t_expect r;
        r.kind = kind;
        r.rid = rid;
        r.notify = notify;
        r.ev_valid = ev_valid;
        r.ev_id = ev_id;
        r.last = last;
        return r;
    endfunction

    function automatic void expect_beat(t_expect r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void drop_slot(int unsigned idx);
        for (int unsigned j = idx; j + 1 < slot_count; j++) begin
            slot_key[j] = slot_key[j + 1];
            slot_owner[j] = slot_owner[j + 1];
            slot_variant[j] = slot_variant[j + 1];
            slot_stamp[j] = slot_stamp[j + 1];
        end
        slot_count--;
    endfunction

    function automatic void predict_cache(kluc_pkg::t_op op, logic [31:0] key,
                                          logic [31:0] owner, logic [31:0] new_id,
                                          logic create_ok);
        int unsigned oldest;
        int unsigned idx;
        int          removed;
        logic [31:0] ev_id;
        logic [31:0] v;
        ev_id = '0;
        removed = 0;
        if (op == kluc_pkg::OP_LOOKUP) begin
            for (int unsigned j = 0; j < slot_count; j++) begin
                if (slot_key[j] == key) begin
                    stamp_counter++;
                    slot_stamp[j] = stamp_counter;
                    expect_beat(make_result(kluc_pkg::K_HIT, slot_variant[j],
                                            1'b0, 1'b0, 32'h0, 1'b1));
                    return;
                end
            end
            if (!create_ok) begin
                expect_beat(make_result(kluc_pkg::K_FAILED, owner, 1'b0, 1'b0, 32'h0, 1'b1));
                return;
            end
            if (slot_count >= NSLOT) begin
                oldest = 0;
                for (int unsigned j = 1; j < slot_count; j++)
                    if (slot_stamp[j] < slot_stamp[oldest]) oldest = j;
                ev_id = slot_variant[oldest];
                drop_slot(oldest);
            end
            stamp_counter++;
            slot_key[slot_count] = key;
            slot_owner[slot_count] = owner;
            slot_variant[slot_count] = new_id;
            slot_stamp[slot_count] = stamp_counter;
            slot_count++;
            expect_beat(make_result(kluc_pkg::K_INSERTED, new_id, 1'b0, ev_id != 0,
                                    ev_id, 1'b1));
        end else begin
            idx = 0;
            while (idx < slot_count) begin
                if (slot_owner[idx] == owner) begin
                    v = slot_variant[idx];
                    expect_beat(make_result(kluc_pkg::K_REMOVED, v, v != 0, 1'b0,
                                            32'h0, 1'b0));
                    removed++;
                    drop_slot(idx);
                end else begin
                    idx++;
                end
            end
            if (removed == 0)
                expect_beat(make_result(kluc_pkg::K_NONE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b1));
            else
                pending_results[$].last = 1'b1;
        end
    endfunction

    task automatic send_item(kluc_pkg::t_op op, logic [31:0] key, logic [31:0] owner,
                             logic [31:0] new_id, logic create_ok);
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= {8'($urandom), $urandom, $urandom, $urandom};
            i_s_axis_tuser <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= {7'd0, create_ok, new_id, owner, key};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_cache(op, key, owner, new_id, create_ok);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected beat: kind %0d id %h", o_m_axis_tuser,
                             o_m_axis_tdata[31:0]);
            end else begin
                e = pending_results.pop_front();
                if (o_m_axis_tuser !== e.kind || o_m_axis_tdata[31:0] !== e.rid
                    || o_m_axis_tdata[32] !== e.notify || o_m_axis_tdata[33] !== e.ev_valid
                    || o_m_axis_tdata[65:34] !== e.ev_id || o_m_axis_tdata[71:66] !== '0
                    || o_m_axis_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected kind %0d id %h n %b ev %b %h last %b,",
                                 e.kind, e.rid, e.notify, e.ev_valid, e.ev_id, e.last,
                                 " got kind %0d id %h n %b ev %b %h last %b",
                                 o_m_axis_tuser, o_m_axis_tdata[31:0], o_m_axis_tdata[32],
                                 o_m_axis_tdata[33], o_m_axis_tdata[65:34], o_m_axis_tlast);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_extremes();
        send_item(kluc_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0);
        send_item(kluc_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b1);
        send_item(kluc_pkg::OP_LOOKUP, 32'h0, 32'h1, 32'h5, 1'b1);
        send_item(kluc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_item(kluc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);
        send_item(kluc_pkg::OP_LOOKUP, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_item(kluc_pkg::OP_PURGE, 32'hFFFF_FFFF, 32'h7777_7777, 32'hFFFF_FFFF, 1'b1);
        send_item(kluc_pkg::OP_PURGE, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_item(kluc_pkg::OP_PURGE, 32'h0, 32'h0, 32'h0, 1'b0);
        send_item(kluc_pkg::OP_PURGE, 32'h0, 32'h0, 32'h0, 1'b0);
    endtask

    // Fill the cache, touch some entries, then overflow so that eviction picks the
    // least recently used slot, including slots holding a zero variant id, then purge by owner.
    task automatic test_eviction();
        for (int k = 0; k < NSLOT; k++)
            send_item(kluc_pkg::OP_LOOKUP, 32'hA000_0000 + k, 32'h50 + (k % 3),
                      (k % 5 == 0) ? 32'h0 : 32'hB000_0000 + k, 1'b1);
        send_item(kluc_pkg::OP_LOOKUP, 32'hA000_0000, 32'h0, 32'h0, 1'b0);
        send_item(kluc_pkg::OP_LOOKUP, 32'hA000_0003, 32'h0, 32'h0, 1'b0);
        for (int k = 0; k < 8; k++)
            send_item(kluc_pkg::OP_LOOKUP, 32'hC000_0000 + k, 32'h60, $urandom, 1'b1);
        send_item(kluc_pkg::OP_PURGE, 32'h0, 32'h51, 32'h0, 1'b0);
        send_item(kluc_pkg::OP_PURGE, 32'h0, 32'h60, 32'h0, 1'b0);
        send_item(kluc_pkg::OP_PURGE, 32'h0, 32'h50, 32'h0, 1'b0);
        send_item(kluc_pkg::OP_PURGE, 32'h0, 32'h52, 32'h0, 1'b0);
    endtask

    task automatic test_random(int count);
        kluc_pkg::t_op op;
        int            pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            op = (pick < 15) ? kluc_pkg::OP_PURGE : kluc_pkg::OP_LOOKUP;
            if (pick < 10)
                send_item(op, $urandom, owner_pool[$urandom_range(3)], $urandom,
                          1'($urandom_range(1)));
            else if (pick < 15)
                send_item(op, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
            else if (pick < 85)
                send_item(op, key_pool[$urandom_range(7)] + $urandom_range(5),
                          owner_pool[$urandom_range(3)], $urandom, $urandom_range(99) < 80);
            else
                send_item(op, $urandom, $urandom, $urandom, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        slot_count = 0;
        stamp_counter = '0;
        send_gap_pct = 38;
        recv_stall_pct = 86;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_m_axis_tready = 1'b0;
        for (int k = 0; k < 8; k++) key_pool[k] = $urandom;
        for (int k = 0; k < 4; k++) owner_pool[k] = $urandom;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes();
        test_eviction();
        test_random(22);
        send_gap_pct = 86;
        recv_stall_pct = 38;
        test_random(22);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random(22);
        drain_results();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/kluc_pkg.sv
rtl/core/kluc_front.sv
rtl/core/kluc_back.sv
rtl/core/keyed_lru_cache_with_owner_purge_unit.sv
tb/tb_keyed_lru_cache_with_owner_purge_unit.sv
